### hdl/ssrq_pkg.sv
`default_nettype none

package ssrq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int LAP_BITS_DEF  = 24;
	localparam int DATA_BITS_DEF = 32;

	localparam int CFG_BITS    = 5;
	localparam int ACTION_BITS = 2;
	localparam int STATUS_BITS = 2;

	localparam logic [CFG_BITS-1:0] SLOT_COUNT_RESET = 5'd16;

	localparam logic [ACTION_BITS-1:0] ACT_PUSH = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_POP  = 2'd1;

	localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_OVERFLOW = 2'd2;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_we;  // zero one stamp slot, step the sweep counter
		logic push;    // write the tail slot, load an ok result
		logic rd_go;   // latch action of a pop/check word
		logic eval;    // compare head stamp, load result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic out_hold;
		logic is_push;
	} stat_t;

endpackage

`default_nettype wire

### hdl/ssrq_ctrl.sv
`default_nettype none

module ssrq_ctrl import ssrq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (stat.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				// output register must be free or draining this cycle
				in_stall = stat.out_hold;
				if (in_valid && !stat.out_hold) begin
					if (stat.is_push) begin
						cmd.push = 1'b1;
					end else begin
						cmd.rd_go = 1'b1;
						state_nxt = S_EVAL;
					end
				end
			end
			S_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/ssrq_dp.sv
`default_nettype none

module ssrq_dp import ssrq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int LAP_BITS  = LAP_BITS_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [ACTION_BITS-1:0] action,
	input  wire logic [DATA_BITS-1:0]   data_in,
	input  wire logic                   cfg_valid,
	input  wire logic [CFG_BITS-1:0]    cfg_data,
	input  wire logic                   out_stall,
	input  wire cmd_t                   cmd,
	output stat_t                       stat,
	output logic                        out_valid,
	output logic [STATUS_BITS-1:0]      status,
	output logic [DATA_BITS-1:0]        data_out
);

	localparam int IDX_BITS = $clog2(DEPTH);
	localparam int CNT_RAW  = $clog2(DEPTH + 1);
	localparam int CNT_BITS = (CNT_RAW > CFG_BITS) ? CNT_RAW : CFG_BITS;

	logic [LAP_BITS-1:0]  stamp_mem [DEPTH];
	logic [DATA_BITS-1:0] data_mem  [DEPTH];

	logic [CFG_BITS-1:0]    cfg_q;
	logic [IDX_BITS-1:0]    head_q, tail_q, clr_q;
	logic [LAP_BITS-1:0]    rlap_q, wlap_q;
	logic [ACTION_BITS-1:0] act_q;
	logic [LAP_BITS-1:0]    stamp_rd_q;
	logic [DATA_BITS-1:0]   data_rd_q;
	logic                   out_valid_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [DATA_BITS-1:0]   dout_q;

	logic [CNT_BITS-1:0] cfg_ext, live;
	logic                tail_wrap, head_wrap;
	logic [IDX_BITS-1:0] tail_nxt, head_nxt;
	logic                hit, prev_hit, pop_ok;

	// slot_count of 0 acts as 1, above DEPTH acts as DEPTH
	always_comb begin
		cfg_ext = CNT_BITS'(cfg_q);
		if (cfg_ext == '0) begin
			live = CNT_BITS'(1);
		end else if (cfg_ext > CNT_BITS'(DEPTH)) begin
			live = CNT_BITS'(DEPTH);
		end else begin
			live = cfg_ext;
		end
	end

	assign tail_wrap = (CNT_BITS'(tail_q) + CNT_BITS'(1)) >= live;
	assign head_wrap = (CNT_BITS'(head_q) + CNT_BITS'(1)) >= live;
	assign tail_nxt  = tail_wrap ? '0 : tail_q + IDX_BITS'(1);
	assign head_nxt  = head_wrap ? '0 : head_q + IDX_BITS'(1);

	assign hit      = stamp_rd_q == rlap_q;
	assign prev_hit = stamp_rd_q == (rlap_q - LAP_BITS'(1));
	assign pop_ok   = hit && (act_q == ACT_POP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= SLOT_COUNT_RESET;
			head_q <= '0;
			tail_q <= '0;
			clr_q  <= '0;
			rlap_q <= LAP_BITS'(1);
			wlap_q <= LAP_BITS'(1);
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			if (cmd.clr_we) begin
				clr_q <= clr_q + IDX_BITS'(1);
			end
			if (cmd.push) begin
				tail_q <= tail_nxt;
				if (tail_wrap) begin
					wlap_q <= wlap_q + LAP_BITS'(1);
				end
			end
			if (cmd.eval && pop_ok) begin
				head_q <= head_nxt;
				if (head_wrap) begin
					rlap_q <= rlap_q + LAP_BITS'(1);
				end
			end
		end
	end

	// slot stores: one write port, head slot read every cycle
	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			stamp_mem[clr_q] <= '0;
		end else if (cmd.push) begin
			stamp_mem[tail_q] <= wlap_q;
			data_mem[tail_q]  <= data_in;
		end
	end

	always_ff @(posedge clk) begin
		stamp_rd_q <= stamp_mem[head_q];
		data_rd_q  <= data_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_go) begin
			act_q <= action;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push || cmd.eval) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			status_q <= STAT_OK;
			dout_q   <= '0;
		end else if (cmd.eval) begin
			if (hit) begin
				status_q <= STAT_OK;
			end else if (prev_hit) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q <= STAT_OVERFLOW;
			end
			dout_q <= pop_ok ? data_rd_q : '0;
		end
	end

	assign stat.clr_last = clr_q == IDX_BITS'(DEPTH - 1);
	assign stat.out_hold = out_valid_q && out_stall;
	assign stat.is_push  = action == ACT_PUSH;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = dout_q;

`ifndef SYNTHESIS
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !(out_valid_q && out_stall))
		else $error("push loaded over a held result");
	a_eval_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> !out_valid_q)
		else $error("compare result would overwrite a pending word");
	a_push_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_valid_q && (status_q == STAT_OK) && (dout_q == '0))
		else $error("push did not produce an ok result");
`endif

endmodule

`default_nettype wire

### hdl/sequence_stamped_ring_queue.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------
// in       | in_valid / in_stall  | action, data_in
// out      | out_valid / out_stall| status, data_out
// cfg      | cfg_valid / cfg_ready| cfg_data (slot_count)
//
// A push loads the result register directly; a pop or check passes through an
// evaluate state, set by the registered read of the head slot's stamp and data.
// After reset the stamp store is zeroed one slot a cycle, with in_stall high
// until the last slot is cleared; cfg writes are taken throughout.
// A new word is taken while the result register is empty or drains in the
// same cycle; out_stall holds the result and stalls the input side.
`default_nettype none

module sequence_stamped_ring_queue import ssrq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int LAP_BITS  = LAP_BITS_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [ACTION_BITS-1:0] action,
	input  wire logic [DATA_BITS-1:0]   data_in,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [STATUS_BITS-1:0]      status,
	output logic [DATA_BITS-1:0]        data_out,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_BITS-1:0]    cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	ssrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ssrq_dp #(
		.DEPTH     (DEPTH),
		.LAP_BITS  (LAP_BITS),
		.DATA_BITS (DATA_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.action    (action),
		.data_in   (data_in),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.status    (status),
		.data_out  (data_out)
	);

endmodule

`default_nettype wire
